@@ src/mhpq_pkg.sv @@
// Shared constants and codes for the max-heap priority queue.
package mhpq_pkg;

   localparam int DEPTH      = 64;
   localparam int DATA_WIDTH = 32;
   localparam int ADDR_W     = $clog2(DEPTH);
   localparam int IDX_W      = $clog2(DEPTH + 1);
   localparam int CAP_W      = 7;
   localparam int STATUS_W   = 2;
   localparam int CMP_W      = (IDX_W > CAP_W) ? IDX_W : CAP_W;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_REMOVE = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

   typedef logic signed [DATA_WIDTH-1:0] data_type;

endpackage

@@ src/mhpq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module mhpq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/max_heap_priority_queue.sv @@
// Top level of the binary max-heap priority queue with its sequencer.
//
// Usage:
//   Command channel: drive req_func (0 insert, 1 remove max) and req_value with
//   start high; the beat is taken on an edge where busy is low.
//   Result channel: rsp_valid is high for exactly one cycle with
//   rsp_result_value, rsp_status (0 ok, 1 full, 2 empty) and rsp_fill_count.
//   The receiver cannot stall; each result must be taken when shown.
//   Config: csr_wr_en with csr_wr_data writes capacity (values above the
//   heap depth saturate to the depth); write only while idle.
// Sequence:
//   From the accepting edge busy is high until the result strobe, except for
//   a full insert or an empty remove (busy stays low). Insert: a parent read
//   and compare per level climbed, ending at the root or on a compare. Remove:
//   read root, then tail, then per level descended the left and right child
//   (left only if lone). The heap RAM's single registered read port sets these steps.
// Reset:
//   Synchronous, active high: the heap is emptied and capacity returns to 64.
//   The RAM needs no clearing pass.
module max_heap_priority_queue (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic                                   req_func,
   input  logic signed [mhpq_pkg::DATA_WIDTH-1:0] req_value,
   output logic                                   rsp_valid,
   output logic signed [mhpq_pkg::DATA_WIDTH-1:0] rsp_result_value,
   output logic [mhpq_pkg::STATUS_W-1:0]          rsp_status,
   output logic [mhpq_pkg::CAP_W-1:0]             rsp_fill_count,
   input  logic                                   csr_wr_en,
   input  logic [mhpq_pkg::CAP_W-1:0]             csr_wr_data
);

   localparam int IDX_W  = mhpq_pkg::IDX_W;
   localparam int ADDR_W = mhpq_pkg::ADDR_W;
   localparam int CMP_W  = mhpq_pkg::CMP_W;

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_UP_CHK  = 3'd1;
   localparam logic [2:0] ST_UP_CMP  = 3'd2;
   localparam logic [2:0] ST_RM_ROOT = 3'd3;
   localparam logic [2:0] ST_RM_LAST = 3'd4;
   localparam logic [2:0] ST_DN_CHK  = 3'd5;
   localparam logic [2:0] ST_DN_LEFT = 3'd6;
   localparam logic [2:0] ST_DN_RGT  = 3'd7;

   logic [2:0]                  state_ff, state_in;
   logic [mhpq_pkg::CAP_W-1:0]  cap_ff;
   logic [IDX_W-1:0]            count_ff, count_in;
   logic [IDX_W-1:0]            pos_ff, pos_in;
   mhpq_pkg::data_type          cur_ff, cur_in;
   mhpq_pkg::data_type          left_ff, left_in;
   mhpq_pkg::data_type          result_ff, result_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   mhpq_pkg::data_type          rsp_value_ff, rsp_value_in;
   logic [mhpq_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [mhpq_pkg::CAP_W-1:0]  rsp_fill_ff, rsp_fill_in;

   logic                        wr_en;
   logic [ADDR_W-1:0]           wr_addr;
   mhpq_pkg::data_type          wr_data;
   logic [ADDR_W-1:0]           rd_addr;
   logic [mhpq_pkg::DATA_WIDTH-1:0] rd_raw;
   mhpq_pkg::data_type          rd_data;

   logic [CMP_W-1:0]            cap_wide, depth_wide, cap_sat, count_wide;
   logic                        has_room;
   logic [IDX_W:0]              lft_idx, n_wide;
   logic [IDX_W-1:0]            parent_idx;
   logic [ADDR_W-1:0]           pos_addr, parent_addr, lft_addr, rgt_addr;
   logic                        rgt_gt_lft, rgt_gt_cur, lft_gt_cur, cur_gt_rd;

   mhpq_ram #(
      .WIDTH (mhpq_pkg::DATA_WIDTH),
      .DEPTH (mhpq_pkg::DEPTH)
   ) u_heap_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   assign rd_data = $signed(rd_raw);

   assign cap_wide   = CMP_W'(cap_ff);
   assign depth_wide = CMP_W'(mhpq_pkg::DEPTH);
   assign cap_sat    = (cap_wide > depth_wide) ? depth_wide : cap_wide;
   assign count_wide = CMP_W'(count_ff);
   assign has_room   = count_wide < cap_sat;

   assign lft_idx     = {pos_ff, 1'b0};
   assign n_wide      = {1'b0, count_ff};
   assign parent_idx  = pos_ff >> 1;
   assign pos_addr    = ADDR_W'(pos_ff - IDX_W'(1));
   assign parent_addr = ADDR_W'(parent_idx - IDX_W'(1));
   assign lft_addr    = ADDR_W'(lft_idx - (IDX_W+1)'(1));
   assign rgt_addr    = lft_idx[ADDR_W-1:0];

   assign cur_gt_rd  = cur_ff > rd_data;
   assign rgt_gt_lft = rd_data > left_ff;
   assign rgt_gt_cur = rd_data > cur_ff;
   assign lft_gt_cur = left_ff > cur_ff;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      pos_in        = pos_ff;
      cur_in        = cur_ff;
      left_in       = left_ff;
      result_in     = result_ff;
      rsp_valid_in  = 1'b0;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_fill_in   = rsp_fill_ff;
      wr_en         = 1'b0;
      wr_addr       = pos_addr;
      wr_data       = cur_ff;
      rd_addr       = pos_addr;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               result_in = '0;
               if (req_func == mhpq_pkg::FUNC_INSERT) begin
                  if (has_room) begin
                     count_in = count_ff + IDX_W'(1);
                     pos_in   = count_ff + IDX_W'(1);
                     cur_in   = req_value;
                     state_in = ST_UP_CHK;
                  end else begin
                     rsp_valid_in  = 1'b1;
                     rsp_value_in  = '0;
                     rsp_status_in = mhpq_pkg::STATUS_FULL;
                     rsp_fill_in   = mhpq_pkg::CAP_W'(count_ff);
                  end
               end else begin
                  if (count_ff == '0) begin
                     rsp_valid_in  = 1'b1;
                     rsp_value_in  = '0;
                     rsp_status_in = mhpq_pkg::STATUS_EMPTY;
                     rsp_fill_in   = mhpq_pkg::CAP_W'(count_ff);
                  end else begin
                     rd_addr  = '0;
                     state_in = ST_RM_ROOT;
                  end
               end
            end
         end
         ST_UP_CHK: begin
            if (pos_ff == IDX_W'(1)) begin
               wr_en    = 1'b1;
               state_in = ST_IDLE;
            end else begin
               rd_addr  = parent_addr;
               state_in = ST_UP_CMP;
            end
         end
         ST_UP_CMP: begin
            wr_en = 1'b1;
            if (cur_gt_rd) begin
               wr_data  = rd_data;
               pos_in   = parent_idx;
               state_in = ST_UP_CHK;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_RM_ROOT: begin
            result_in = rd_data;
            rd_addr   = ADDR_W'(count_ff - IDX_W'(1));
            state_in  = ST_RM_LAST;
         end
         ST_RM_LAST: begin
            cur_in   = rd_data;
            count_in = count_ff - IDX_W'(1);
            pos_in   = IDX_W'(1);
            state_in = ST_DN_CHK;
         end
         ST_DN_CHK: begin
            if (lft_idx > n_wide) begin
               wr_en    = 1'b1;
               state_in = ST_IDLE;
            end else begin
               rd_addr  = lft_addr;
               state_in = ST_DN_LEFT;
            end
         end
         ST_DN_LEFT: begin
            left_in = rd_data;
            if (lft_idx < n_wide) begin
               rd_addr  = rgt_addr;
               state_in = ST_DN_RGT;
            end else begin
               wr_en = 1'b1;
               if (rd_data > cur_ff) begin
                  wr_data  = rd_data;
                  pos_in   = IDX_W'(lft_idx);
                  state_in = ST_DN_CHK;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_DN_RGT: begin
            wr_en = 1'b1;
            if (rgt_gt_lft) begin
               if (rgt_gt_cur) begin
                  wr_data  = rd_data;
                  pos_in   = IDX_W'(lft_idx + (IDX_W+1)'(1));
                  state_in = ST_DN_CHK;
               end else begin
                  state_in = ST_IDLE;
               end
            end else begin
               if (lft_gt_cur) begin
                  wr_data  = left_ff;
                  pos_in   = IDX_W'(lft_idx);
                  state_in = ST_DN_CHK;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // completion of a multi-cycle operation
      if (state_ff != ST_IDLE && state_in == ST_IDLE) begin
         rsp_valid_in  = 1'b1;
         rsp_value_in  = result_ff;
         rsp_status_in = mhpq_pkg::STATUS_OK;
         rsp_fill_in   = mhpq_pkg::CAP_W'(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         cap_ff       <= mhpq_pkg::CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      cur_ff        <= cur_in;
      left_ff       <= left_in;
      result_ff     <= result_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_fill_ff   <= rsp_fill_in;
   end

   assign busy             = state_ff != ST_IDLE;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_fill_count   = rsp_fill_ff;

endmodule

@@ verif/mhpq_checker.sv @@
// Checker for the max-heap priority queue: tracks the heap and compares every result beat.
module mhpq_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  logic                          req_func,
   input  mhpq_pkg::data_type            req_value,
   input  logic                          rsp_valid,
   input  mhpq_pkg::data_type            rsp_result_value,
   input  logic [mhpq_pkg::STATUS_W-1:0] rsp_status,
   input  logic [mhpq_pkg::CAP_W-1:0]    rsp_fill_count,
   input  logic                          csr_wr_en,
   input  logic [mhpq_pkg::CAP_W-1:0]    csr_wr_data,
   output int                            fail_count,
   output int                            outcomes_left
);

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      mhpq_pkg::data_type              value;
      logic [mhpq_pkg::STATUS_W-1:0]   status;
      logic [mhpq_pkg::CAP_W-1:0]      fill;
   } heap_outcome_type;

   mhpq_pkg::data_type           heap_mem [1:mhpq_pkg::DEPTH];
   int unsigned                  heap_fill;
   logic [mhpq_pkg::CAP_W-1:0]   cap_reg;
   heap_outcome_type             outcome_q [$];
   int                           errs;

   assign fail_count = errs;

   function automatic void heap_swap(int unsigned a, int unsigned b);
      mhpq_pkg::data_type tmp;
      tmp = heap_mem[a];
      heap_mem[a] = heap_mem[b];
      heap_mem[b] = tmp;
   endfunction

   function automatic heap_outcome_type heap_apply(logic f, mhpq_pkg::data_type v);
      heap_outcome_type o;
      int unsigned      lim;
      int unsigned      pos;
      int unsigned      kid;
      o.value = '0;
      o.status = mhpq_pkg::STATUS_OK;
      lim = (cap_reg > mhpq_pkg::DEPTH) ? mhpq_pkg::DEPTH : cap_reg;
      if (f == mhpq_pkg::FUNC_INSERT) begin
         if (heap_fill < lim) begin
            heap_fill++;
            heap_mem[heap_fill] = v;
            pos = heap_fill;
            while (pos > 1 && heap_mem[pos] > heap_mem[pos / 2]) begin
               heap_swap(pos, pos / 2);
               pos = pos / 2;
            end
         end else begin
            o.status = mhpq_pkg::STATUS_FULL;
         end
      end else if (heap_fill > 0) begin
         o.value = heap_mem[1];
         heap_mem[1] = heap_mem[heap_fill];
         heap_mem[heap_fill] = '0;
         heap_fill--;
         pos = 1;
         while (2 * pos <= heap_fill) begin
            kid = 2 * pos;
            if (kid < heap_fill && heap_mem[kid + 1] > heap_mem[kid])
               kid++;
            if (!(heap_mem[kid] > heap_mem[pos]))
               break;
            heap_swap(pos, kid);
            pos = kid;
         end
      end else begin
         o.status = mhpq_pkg::STATUS_EMPTY;
      end
      o.fill = mhpq_pkg::CAP_W'(heap_fill);
      return o;
   endfunction

   always @(posedge clock) begin : watch
      heap_outcome_type want;
      if (reset) begin
         outcome_q.delete();
         heap_fill = 0;
         cap_reg = mhpq_pkg::CAP_RESET;
      end else begin
         // older beat is retired before a new command is queued
         if (rsp_valid) begin
            if (outcome_q.size() == 0) begin
               errs++;
               $display("%0t result beat expected none actual value %0d status %0d fill %0d",
                        $time, rsp_result_value, rsp_status, rsp_fill_count);
            end else begin
               want = outcome_q.pop_front();
               if (rsp_result_value !== want.value) begin
                  errs++;
                  $display("%0t result_value expected %0d actual %0d",
                           $time, want.value, rsp_result_value);
               end
               if (rsp_status !== want.status) begin
                  errs++;
                  $display("%0t status expected %0d actual %0d",
                           $time, want.status, rsp_status);
               end
               if (rsp_fill_count !== want.fill) begin
                  errs++;
                  $display("%0t fill_count expected %0d actual %0d",
                           $time, want.fill, rsp_fill_count);
               end
            end
         end
         if (start && !busy)
            outcome_q.push_back(heap_apply(req_func, req_value));
         if (csr_wr_en)
            cap_reg = csr_wr_data;
      end
      outcomes_left <= outcome_q.size();
   end

endmodule

@@ verif/max_heap_priority_queue_tb.sv @@
// Testbench top for the max-heap priority queue: clock, reset, command stimulus and verdict.
module max_heap_priority_queue_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASES      = 10;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          start = 1'b0;
   logic                          busy;
   logic                          req_func = mhpq_pkg::FUNC_INSERT;
   mhpq_pkg::data_type            req_value = '0;
   logic                          rsp_valid;
   mhpq_pkg::data_type            rsp_result_value;
   logic [mhpq_pkg::STATUS_W-1:0] rsp_status;
   logic [mhpq_pkg::CAP_W-1:0]    rsp_fill_count;
   logic                          csr_wr_en = 1'b0;
   logic [mhpq_pkg::CAP_W-1:0]    csr_wr_data = '0;

   int fail_count;
   int outcomes_left;
   int cycle_count = 0;
   bit idle_on = 1'b1;

   int phase_cap [PHASES]  = '{64, 3, 127, 1, 0, 2, 65, 7, 64, 20};
   int phase_ins [PHASES]  = '{85, 50, 70, 40, 50, 60, 90, 50, 30, 60};
   int phase_len [PHASES]  = '{70, 50, 60, 40, 20, 50, 90, 50, 80, 60};

   always #1ns clock = ~clock;

   max_heap_priority_queue uut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_func         (req_func),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_result_value (rsp_result_value),
      .rsp_status       (rsp_status),
      .rsp_fill_count   (rsp_fill_count),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   mhpq_checker checker_i (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_func         (req_func),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_result_value (rsp_result_value),
      .rsp_status       (rsp_status),
      .rsp_fill_count   (rsp_fill_count),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .fail_count       (fail_count),
      .outcomes_left    (outcomes_left)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("max_heap_priority_queue: mismatch");
         $finish;
      end
   end

   function automatic mhpq_pkg::data_type rand_value();
      case ($urandom_range(9))
         0:       return 32'sh7FFF_FFFF;
         1:       return mhpq_pkg::data_type'(32'h8000_0000);
         2, 3:    return mhpq_pkg::data_type'(int'($urandom_range(6)) - 3);
         default: return mhpq_pkg::data_type'($urandom);
      endcase
   endfunction

   task automatic send_cmd(input logic f, input mhpq_pkg::data_type v);
      while (idle_on && $urandom_range(99) < 26) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_func <= f;
      req_value <= v;
      do @(posedge clock); while (busy);
   endtask

   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (outcomes_left != 0 || busy);
   endtask

   task automatic write_capacity(input int c);
      drain();
      csr_wr_en <= 1'b1;
      csr_wr_data <= mhpq_pkg::CAP_W'(c);
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_cmd(mhpq_pkg::FUNC_REMOVE, rand_value());
      send_cmd(mhpq_pkg::FUNC_INSERT, 32'sh7FFF_FFFF);
      send_cmd(mhpq_pkg::FUNC_INSERT, mhpq_pkg::data_type'(32'h8000_0000));
      send_cmd(mhpq_pkg::FUNC_INSERT, 32'sd0);
      send_cmd(mhpq_pkg::FUNC_INSERT, -32'sd1);
      send_cmd(mhpq_pkg::FUNC_INSERT, 32'sd1);
      repeat (5) send_cmd(mhpq_pkg::FUNC_REMOVE, rand_value());
      // root refilled from the tail ends up with a lone left child
      send_cmd(mhpq_pkg::FUNC_INSERT, 32'sd9);
      send_cmd(mhpq_pkg::FUNC_INSERT, 32'sd8);
      send_cmd(mhpq_pkg::FUNC_INSERT, 32'sd1);
      repeat (3) send_cmd(mhpq_pkg::FUNC_REMOVE, rand_value());
      write_capacity(0);
      send_cmd(mhpq_pkg::FUNC_INSERT, 32'sd4);
      write_capacity(1);
      send_cmd(mhpq_pkg::FUNC_INSERT, 32'sd5);
      send_cmd(mhpq_pkg::FUNC_INSERT, 32'sd5);
      write_capacity(127);
      send_cmd(mhpq_pkg::FUNC_INSERT, 32'sd5);
      send_cmd(mhpq_pkg::FUNC_INSERT, 32'sd6);
      // capacity below the current fill
      write_capacity(1);
      send_cmd(mhpq_pkg::FUNC_INSERT, 32'sd7);
      send_cmd(mhpq_pkg::FUNC_REMOVE, rand_value());
      send_cmd(mhpq_pkg::FUNC_REMOVE, rand_value());

      for (int p = 0; p < PHASES; p++) begin
         idle_on = (p != 2 && p != 6);
         write_capacity((p == PHASES - 1) ? int'($urandom_range(127)) : phase_cap[p]);
         repeat (phase_len[p])
            send_cmd(($urandom_range(99) < phase_ins[p]) ? mhpq_pkg::FUNC_INSERT
                                                         : mhpq_pkg::FUNC_REMOVE,
                     rand_value());
      end

      drain();
      repeat (40) @(posedge clock);
      if (fail_count == 0 && outcomes_left == 0)
         $display("max_heap_priority_queue: match");
      else
         $display("max_heap_priority_queue: mismatch");
      $finish;
   end

endmodule
